// ----- hdl/mexp_pkg.sv -----
// Shared types, constants and modular-add helper for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_ADDR_W = 2;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_MODULUS  = 2'd0;
  localparam cfg_addr_t CFG_EXPONENT = 2'd1;

  // start a bit-serial multiply: prod = x * y mod m, x below m, y any value
  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mul_req_t;

  // (a + b) mod m for a, b below m
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    logic [WORD_W:0] sum;
    logic [WORD_W:0] dif;
    sum = {1'b0, a} + {1'b0, b};
    dif = sum - {1'b0, m};
    return (sum >= {1'b0, m}) ? dif[WORD_W-1:0] : sum[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mexp_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, LSB first.
`default_nettype none

module mexp_mulmod (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire mexp_pkg::mul_req_t req_i,
  input  wire mexp_pkg::word_t    mod_i,
  output logic                    done_o,
  output mexp_pkg::word_t         prod_o
);

  logic            busy_q, busy_d;
  mexp_pkg::word_t acc_q, acc_d;
  mexp_pkg::word_t addend_q, addend_d;
  mexp_pkg::word_t y_q, y_d;

  // finished once no multiplier bits remain
  assign done_o = busy_q && (y_q == '0);
  assign prod_o = acc_q;

  always_comb begin
    busy_d   = busy_q;
    acc_d    = acc_q;
    addend_d = addend_q;
    y_d      = y_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      acc_d    = '0;
      addend_d = req_i.x;
      y_d      = req_i.y;
    end else if (busy_q) begin
      if (y_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (y_q[0]) begin
          acc_d = mexp_pkg::add_mod(acc_q, addend_q, mod_i);
        end
        addend_d = mexp_pkg::add_mod(addend_q, addend_q, mod_i);
        y_d      = y_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    addend_q <= addend_d;
    y_q      <= y_d;
  end

endmodule

`default_nettype wire

// ----- hdl/modular_exponentiation_64.sv -----
// Top level: square-and-multiply modular exponentiation over 64-bit words.
`default_nettype none

// Usage
//   Config: write modulus (index 0, reset 2) and exponent (index 1, reset 1)
//   through cfg_we_i / cfg_addr_i / cfg_wdata_i while idle; other indexes are ignored.
//   Input: one word per message on s_axis_*; tdata holds the message.
//   Output: one word per message on m_axis_*; tdata holds message^exponent
//   mod modulus, tuser flags a message not below the modulus (the message is
//   still reduced and used). A modulus below 2 gives result 0.
// Operation
//   One shared bit-serial multiplier does all the work, one multiplier bit a
//   cycle. The message is first reduced, then each exponent bit up to the
//   highest set one costs a step state plus up to two multiplier passes.
//   Exponent 0 still runs the reduction. One message is worked on at a time.
// Stall
//   The result sits in an output register; the next message is taken while
//   it waits. A finished second result holds until the register frees.
// Reset
//   Clears control state and loads the register reset values.

module modular_exponentiation_64 (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // config write port
  input  wire                     cfg_we_i,
  input  wire mexp_pkg::cfg_addr_t cfg_addr_i,
  input  wire mexp_pkg::word_t    cfg_wdata_i,
  // input stream
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire mexp_pkg::word_t    s_axis_tdata,   // [63:0] message
  // output stream
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  output mexp_pkg::word_t         m_axis_tdata,   // [63:0] result
  output logic                    m_axis_tuser    // [0] error
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_STEP   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam int unsigned W = mexp_pkg::WORD_W;

  logic [2:0]      state_q, state_d;
  mexp_pkg::word_t modulus_q, exponent_q;
  mexp_pkg::word_t power_q, power_d;
  mexp_pkg::word_t base_q, base_d;
  mexp_pkg::word_t exp_q, exp_d;
  mexp_pkg::word_t res_q, res_d;
  logic            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  mexp_pkg::word_t out_data_q, out_data_d;
  logic            out_err_q, out_err_d;

  mexp_pkg::mul_req_t mul_req;
  logic               mul_done;
  mexp_pkg::word_t    mul_prod;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .mod_i  (modulus_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  always_comb begin
    state_d     = state_q;
    power_d     = power_q;
    base_d      = base_q;
    exp_d       = exp_q;
    res_d       = res_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_err_d   = out_err_q;
    mul_req     = '{start: 1'b0, x: base_q, y: base_q};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          err_d = (s_axis_tdata >= modulus_q);
          if (modulus_q[W-1:1] == '0) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            // message mod m as 1 * message
            power_d = mexp_pkg::word_t'(1);
            exp_d   = exponent_q;
            mul_req = '{start: 1'b1, x: mexp_pkg::word_t'(1), y: s_axis_tdata};
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_done) begin
          base_d  = mul_prod;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (exp_q == '0) begin
          res_d   = power_q;
          state_d = ST_DONE;
        end else if (exp_q[0]) begin
          mul_req = '{start: 1'b1, x: power_q, y: base_q};
          state_d = ST_MUL;
        end else begin
          mul_req = '{start: 1'b1, x: base_q, y: base_q};
          state_d = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          power_d = mul_prod;
          // last set bit: the trailing square is not needed
          if (exp_q[W-1:1] == '0) begin
            res_d   = mul_prod;
            state_d = ST_DONE;
          end else begin
            mul_req = '{start: 1'b1, x: base_q, y: base_q};
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          base_d  = mul_prod;
          exp_d   = exp_q >> 1;
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= mexp_pkg::word_t'(2);
      exponent_q  <= mexp_pkg::word_t'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_addr_i == mexp_pkg::CFG_MODULUS)) begin
        modulus_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_addr_i == mexp_pkg::CFG_EXPONENT)) begin
        exponent_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    power_q    <= power_d;
    base_q     <= base_d;
    exp_q      <= exp_d;
    res_q      <= res_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

endmodule

`default_nettype wire
